@@ hw/rtl/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range minimum segment tree: operation
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rmst_pkg;

  // default number of leaves
  localparam int LEAVES_DEF = 1024;

  // empty-range result and reset value of every tree node
  localparam logic signed [63:0] SENTINEL = 64'sd1000000000000000000;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_ASCEND,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write sentinel at clear address, advance
    logic load_set;   // capture leaf and operand for a set
    logic load_add;   // capture leaf and operand for an add
    logic leaf_wr;    // write new leaf value, fetch its sibling
    logic ascend;     // write parent minimum, move up one level
    logic load_qry;   // capture query bounds, reset running minimum
    logic q_run;      // one query walk and accumulate step
    logic res_load;   // move running minimum into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // clearing pass at last node
    logic at_top;     // parent of current node is the root
    logic busy;       // query bounds still open
    logic res_free;   // output register can take a result
    logic idx_ok;     // requested leaf exists
  } sts_t;

endpackage

@@ hw/rtl/rmst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmst_ctrl
// Controller of the segment tree: sequences the clearing pass, leaf updates
// with their ancestor walk, and the two-ended query walk with its drain.
// ----------------------------------------------------------------------------
module rmst_ctrl
  import rmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] operation,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;
  op_t    op;

  assign op = op_t'(operation);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          unique case (op)
            OP_SET:   if (sts.idx_ok) state_next = ST_LEAF_WR;
            OP_ADD:   if (sts.idx_ok) state_next = ST_LEAF_RD;
            OP_QUERY: state_next = ST_WALK;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LEAF_RD: state_next = ST_LEAF_WR;
      ST_LEAF_WR: state_next = ST_ASCEND;
      ST_ASCEND: begin
        if (sts.at_top) state_next = ST_IDLE;
      end
      ST_WALK: begin
        if (!sts.busy) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          unique case (op)
            OP_SET:   cmd.load_set = sts.idx_ok;
            OP_ADD:   cmd.load_add = sts.idx_ok;
            OP_QUERY: cmd.load_qry = 1'b1;
            default:  cmd.load_qry = 1'b0;
          endcase
        end
      end
      ST_LEAF_RD: cmd = '0;
      ST_LEAF_WR: cmd.leaf_wr = 1'b1;
      ST_ASCEND:  cmd.ascend  = 1'b1;
      ST_WALK:    cmd.q_run   = 1'b1;
      ST_DRAIN:   cmd.q_run   = 1'b1;
      ST_DONE:    cmd.res_load = sts.res_free;
      default:    cmd = '0;
    endcase
  end

  // only one source may drive the memory write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_step, cmd.leaf_wr, cmd.ascend}))
    else $error("more than one memory write in a cycle");

  // a result is only moved into a free output register
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.res_free)
    else $error("result loaded over a pending result");

endmodule

@@ hw/rtl/rmst_dp.sv @@
// ----------------------------------------------------------------------------
// rmst_dp
// Datapath of the segment tree: node memory with one write and two read
// ports, leaf update with saturating add, ancestor recompute, query walk
// with a two-stage minimum pipeline, and the output register.
// ----------------------------------------------------------------------------
module rmst_dp
  import rmst_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cmd_t                              cmd,
  output sts_t                              sts,
  input  logic [$clog2(LEAVES)-1:0]         index,
  input  logic [$clog2(LEAVES + 1)-1:0]     range_end,
  input  logic signed [63:0]                value,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [63:0]                minimum
);

  localparam int NODES  = 2 * LEAVES;
  localparam int IDX_W  = $clog2(LEAVES);
  localparam int END_W  = $clog2(LEAVES + 1);
  localparam int ADDR_W = $clog2(NODES);
  localparam int NW     = ADDR_W + 1;

  localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'(LEAVES);
  localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);
  localparam logic [NW-1:0]     LEAF_BASE_N = NW'(LEAVES);
  localparam logic [END_W-1:0]  END_MAX = END_W'(LEAVES);

  function automatic logic signed [63:0] smin(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // node memory
  logic signed [63:0] mem [NODES];
  logic signed [63:0] rd_a;
  logic signed [63:0] rd_b;
  logic [ADDR_W-1:0]  ra;
  logic [ADDR_W-1:0]  rb;
  logic [ADDR_W-1:0]  wa;
  logic signed [63:0] wd;
  logic               we;

  // update path registers
  logic [ADDR_W-1:0]  k;
  logic [ADDR_W-1:0]  parent;
  logic signed [63:0] operand;
  logic               is_add;
  logic signed [63:0] cur;
  logic signed [63:0] leaf_val;
  logic signed [63:0] parent_val;

  // query path registers
  logic [NW-1:0]      lo;
  logic [NW-1:0]      hi;
  logic [NW-1:0]      hm1;
  logic [END_W-1:0]   end_c;
  logic               busy;
  logic               take_a;
  logic               take_b;
  logic signed [63:0] pair;
  logic signed [63:0] best;

  logic [ADDR_W-1:0]  clr_addr;
  logic               res_valid;
  logic signed [63:0] res_data;

  assign parent     = k >> 1;
  assign leaf_val   = is_add ? sat_add(rd_a, operand) : operand;
  assign parent_val = smin(cur, rd_b);
  assign hm1        = hi - NW'(1);
  assign busy       = lo < hi;
  assign end_c      = (range_end > END_MAX) ? END_MAX : range_end;

  // memory address and write selection
  always_comb begin
    ra = cmd.q_run ? lo[ADDR_W-1:0] : k;
    if (cmd.q_run) begin
      rb = hm1[ADDR_W-1:0];
    end else if (cmd.leaf_wr) begin
      rb = k ^ ADDR_W'(1);
    end else begin
      rb = parent ^ ADDR_W'(1);
    end
    we = cmd.clr_step | cmd.leaf_wr | cmd.ascend;
    if (cmd.clr_step) begin
      wa = clr_addr;
      wd = SENTINEL;
    end else if (cmd.leaf_wr) begin
      wa = k;
      wd = leaf_val;
    end else begin
      wa = parent;
      wd = parent_val;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // leaf update and ancestor walk
  always_ff @(posedge clk) begin
    if (cmd.load_set || cmd.load_add) begin
      k       <= LEAF_BASE + ADDR_W'(index);
      operand <= value;
      is_add  <= cmd.load_add;
    end else if (cmd.leaf_wr) begin
      cur <= leaf_val;
    end else if (cmd.ascend) begin
      cur <= parent_val;
      k   <= parent;
    end
  end

  // query walk and minimum pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_qry) begin
      lo     <= LEAF_BASE_N + NW'(index);
      hi     <= LEAF_BASE_N + NW'(end_c);
      take_a <= 1'b0;
      take_b <= 1'b0;
      pair   <= SENTINEL;
      best   <= SENTINEL;
    end else if (cmd.q_run) begin
      take_a <= busy & lo[0];
      take_b <= busy & hi[0];
      if (busy) begin
        lo <= (lo + NW'(lo[0])) >> 1;
        hi <= hi >> 1;
      end
      pair <= smin(take_a ? rd_a : SENTINEL, take_b ? rd_b : SENTINEL);
      best <= smin(best, pair);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (result_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) res_data <= best;
  end

  assign result_valid = res_valid;
  assign minimum      = res_data;

  // status
  assign sts.clr_last = (clr_addr == LAST_NODE);
  assign sts.at_top   = (parent == ADDR_W'(1));
  assign sts.busy     = busy;
  assign sts.res_free = ~res_valid | result_ready;
  assign sts.idx_ok   = ({1'b0, index} < (IDX_W + 1)'(LEAVES));

  // a walk step never lets the lower bound pass the upper one
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    cmd.q_run && busy |=> lo <= hi)
    else $error("query bounds crossed");

  // running minimum never rises above the sentinel
  a_best: assert property (@(posedge clk) disable iff (rst)
    cmd.q_run |=> best <= SENTINEL)
    else $error("running minimum above sentinel");

  // a loaded result shows up on the output
  a_res: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> result_valid && minimum == $past(best))
    else $error("result not presented");

endmodule

@@ hw/rtl/range_minimum_segment_tree.sv @@
// ----------------------------------------------------------------------------
// range_minimum_segment_tree
// Bottom-up segment tree of signed 64-bit leaves holding range minima:
// set leaf, saturating add to leaf, and half-open range minimum query.
//
//   channel   dir  handshake                  payload
//   item      in   item_valid / item_ready    operation, index, range_end, value
//   result    out  result_valid / result_ready minimum
//
// After reset all 2*LEAVES nodes of the memory are cleared to the sentinel,
// one node a cycle; item_ready stays low meanwhile. Set and add walk one
// tree level per cycle, bounded by the single memory write port; add first
// reads the leaf. A query walks one level per cycle on the two read ports;
// ignored items (bad index or unknown operation) are accepted and dropped.
// A finished result waits in the output register while the next transaction
// is taken; only a second result stalls behind result_ready.
// ----------------------------------------------------------------------------
module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    operation,
  input  logic [$clog2(LEAVES)-1:0]     index,
  input  logic [$clog2(LEAVES + 1)-1:0] range_end,
  input  logic signed [63:0]            value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [63:0]            minimum
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  rmst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .operation  (operation),
    .sts        (sts),
    .cmd        (cmd)
  );

  // tree storage and arithmetic
  rmst_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .index        (index),
    .range_end    (range_end),
    .value        (value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .minimum      (minimum)
  );

endmodule
